// ===== hw/rtl/odo_pkg.sv =====
// ============================================================================
// Odometry package
// Beat types, register indexes, reset values and shared saturation logic for
// the differential-drive odometry block.
// ============================================================================
`timescale 1ns / 1ps

package odo_pkg;

  // Widths of the fixed fields.
  localparam int COUNT_W   = 16;
  localparam int GAIN_W    = 32;
  localparam int VALUE_W   = 32;
  localparam int MAG_W     = COUNT_W + 1;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN = 2'd1;

  // Register reset values.
  localparam logic [GAIN_W-1:0] LINEAR_GAIN_RESET  = 32'd183180;
  localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RESET = 32'd1592900;

  // Input beat.
  typedef struct packed {
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] right_count;
    logic [COUNT_W-1:0] time_ms;
  } odo_in_t;

  // Output beat.
  typedef struct packed {
    logic signed [VALUE_W-1:0] translation;
    logic signed [VALUE_W-1:0] rotation;
    logic signed [VALUE_W-1:0] linear_speed;
    logic signed [VALUE_W-1:0] angular_speed;
    logic                      speed_valid;
  } odo_out_t;

  // Saturate a sign and magnitude pair to 32-bit two's complement.
  function automatic logic [VALUE_W-1:0] sat32(input logic neg,
                                               input logic [VALUE_W:0] mag);
    logic [VALUE_W:0] lim;
    begin
      if (neg) begin
        lim = (mag > {2'b01, {(VALUE_W-1){1'b0}}}) ? {2'b01, {(VALUE_W-1){1'b0}}} : mag;
        sat32 = VALUE_W'(~lim[VALUE_W-1:0] + 1'b1);
      end else begin
        lim = (mag > {2'b00, {(VALUE_W-1){1'b1}}}) ? {2'b00, {(VALUE_W-1){1'b1}}} : mag;
        sat32 = lim[VALUE_W-1:0];
      end
    end
  endfunction

endpackage

// ===== hw/rtl/differential_drive_odometry_unit.sv =====
// ============================================================================
// Differential-drive odometry unit
// Throughput: one sample at a time; the next is taken once the result is
// queued. Each sample passes through the 17-step scaler and, when speeds
// are valid, the 32-step rate divider.
// Reset: gains return to their defaults and the previous sample is cleared.
// ============================================================================
`timescale 1ns / 1ps

module differential_drive_odometry_unit import odo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  odo_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output odo_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } seq_state_t;

  seq_state_t         state;
  logic [GAIN_W-1:0]  linear_gain;
  logic [GAIN_W-1:0]  angular_gain;
  logic [COUNT_W-1:0] last_left;
  logic [COUNT_W-1:0] last_right;
  logic [COUNT_W-1:0] last_time;
  logic               have_last;
  logic [COUNT_W-1:0] dt;
  logic               spd_valid;

  logic               accept;
  logic [COUNT_W-1:0] dl, dr, dt_next;
  logic [MAG_W-1:0]   sum_next, diff_next, sum_mag, diff_mag;
  logic               lin_done, rot_done, lin_div_done, rot_div_done;
  logic [VALUE_W-1:0] trans, rot, lin_spd, ang_spd;
  logic               div_start;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain  <= LINEAR_GAIN_RESET;
      angular_gain <= ANGULAR_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINEAR_GAIN:  linear_gain  <= cfg_data;
        REG_ANGULAR_GAIN: angular_gain <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Wrapped tick deltas, zero before the first sample.
  assign dl = have_last ? COUNT_W'(in_data.left_count - last_left) : '0;
  assign dr = have_last ? COUNT_W'(in_data.right_count - last_right) : '0;
  assign dt_next = COUNT_W'(in_data.time_ms - last_time);

  // Signed sum and difference, then magnitudes for the scalers.
  assign sum_next  = {dl[COUNT_W-1], dl} + {dr[COUNT_W-1], dr};
  assign diff_next = {dr[COUNT_W-1], dr} - {dl[COUNT_W-1], dl};
  assign sum_mag   = sum_next[MAG_W-1] ? MAG_W'(~sum_next + 1'b1) : sum_next;
  assign diff_mag  = diff_next[MAG_W-1] ? MAG_W'(~diff_next + 1'b1) : diff_next;

  odo_mul u_lin_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .neg    (sum_next[MAG_W-1]),
    .mag    (sum_mag),
    .gain   (linear_gain),
    .done   (lin_done),
    .result (trans)
  );

  odo_mul u_rot_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .neg    (diff_next[MAG_W-1]),
    .mag    (diff_mag),
    .gain   (angular_gain),
    .done   (rot_done),
    .result (rot)
  );

  assign div_start = (state == S_MUL) && lin_done && rot_done && spd_valid;

  odo_div u_lin_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .value  (trans),
    .dt     (dt),
    .done   (lin_div_done),
    .result (lin_spd)
  );

  odo_div u_rot_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .value  (rot),
    .dt     (dt),
    .done   (rot_div_done),
    .result (ang_spd)
  );

  // Sample history and sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_left  <= '0;
      last_right <= '0;
      last_time  <= '0;
      have_last  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            dt         <= dt_next;
            spd_valid  <= have_last && (dt_next != '0);
            last_left  <= in_data.left_count;
            last_right <= in_data.right_count;
            last_time  <= in_data.time_ms;
            have_last  <= 1'b1;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          if (lin_done && rot_done) begin
            state <= spd_valid ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (lin_div_done && rot_div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a finished beat while the next sample is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_valid                <= 1'b1;
      out_data.translation     <= trans;
      out_data.rotation        <= rot;
      out_data.linear_speed    <= spd_valid ? lin_spd : '0;
      out_data.angular_speed   <= spd_valid ? ang_spd : '0;
      out_data.speed_valid     <= spd_valid;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/odo_mul.sv =====
// ============================================================================
// Odometry serial scaler
// Multiplies a 17-bit tick magnitude by a Q0.32 gain one multiplier bit per
// cycle, then rounds to Q16.16 and saturates to signed 32 bits.
// ============================================================================
`timescale 1ns / 1ps

module odo_mul import odo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               neg,
  input  logic [MAG_W-1:0]   mag,
  input  logic [GAIN_W-1:0]  gain,
  output logic               done,
  output logic [VALUE_W-1:0] result
);

  localparam int CNT_W = $clog2(MAG_W);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_FIN  = 3'b100
  } mul_state_t;

  mul_state_t       state;
  logic [CNT_W-1:0] cnt;
  logic [GAIN_W-1:0] acc;
  logic [MAG_W-1:0] mplr;
  logic             sign;
  logic [GAIN_W:0]  sum_next;
  logic [VALUE_W:0] round_next;

  // One shift-add step: add the gain when the low multiplier bit is set.
  assign sum_next = {1'b0, acc} + (mplr[0] ? {1'b0, gain} : {(GAIN_W+1){1'b0}});

  // Product bits 48..16 plus the rounding bit 15.
  assign round_next = {acc, mplr[MAG_W-1]} + {{VALUE_W{1'b0}}, mplr[MAG_W-2]};

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            state <= M_RUN;
            cnt   <= '0;
            acc   <= '0;
            mplr  <= mag;
            sign  <= neg;
          end
        end
        M_RUN: begin
          acc  <= sum_next[GAIN_W:1];
          mplr <= {sum_next[0], mplr[MAG_W-1:1]};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(MAG_W - 1)) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          result <= sat32(sign, round_next);
          done   <= 1'b1;
          state  <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/odo_div.sv =====
// ============================================================================
// Odometry serial rate divider
// Forms displacement * 1000 / elapsed ms, one quotient bit per cycle, with
// truncation toward zero and saturation to signed 32 bits.
// ============================================================================
`timescale 1ns / 1ps

module odo_div import odo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  input  logic [COUNT_W-1:0] dt,
  output logic               done,
  output logic [VALUE_W-1:0] result
);

  localparam int CNT_W  = $clog2(VALUE_W);
  localparam int PROD_W = VALUE_W + 10;

  typedef enum logic [4:0] {
    D_IDLE  = 5'b00001,
    D_MAG   = 5'b00010,
    D_SCALE = 5'b00100,
    D_ITER  = 5'b01000,
    D_FIN   = 5'b10000
  } div_state_t;

  div_state_t         state;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] val;
  logic [COUNT_W-1:0] divisor;
  logic               sign;
  logic [VALUE_W-1:0] mag;
  logic [COUNT_W-1:0] rem;
  logic [VALUE_W-1:0] quo;
  logic               ovf;
  logic [PROD_W-1:0]  prod_next;
  logic [COUNT_W+1:0] trial_next;
  logic               zero_q;

  // Times 1000 as 1024 - 16 - 8.
  assign prod_next = {mag, 10'b0} - {6'b0, mag, 4'b0} - {7'b0, mag, 3'b0};

  // Restoring step on the next dividend bit.
  assign trial_next = {1'b0, rem, quo[VALUE_W-1]} - {2'b0, divisor};

  assign zero_q = (quo == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            val     <= value;
            divisor <= dt;
            state   <= D_MAG;
          end
        end
        // Split the displacement into sign and magnitude.
        D_MAG: begin
          sign  <= val[VALUE_W-1];
          mag   <= val[VALUE_W-1] ? VALUE_W'(~val + 1'b1) : val;
          state <= D_SCALE;
        end
        // Scale by 1000; a top part at or above the divisor means the
        // quotient cannot fit in 32 bits.
        D_SCALE: begin
          ovf   <= {6'b0, prod_next[PROD_W-1:VALUE_W]} >= divisor;
          rem   <= {6'b0, prod_next[PROD_W-1:VALUE_W]};
          quo   <= prod_next[VALUE_W-1:0];
          cnt   <= '0;
          state <= D_ITER;
        end
        D_ITER: begin
          if (!trial_next[COUNT_W+1]) begin
            rem <= trial_next[COUNT_W-1:0];
            quo <= {quo[VALUE_W-2:0], 1'b1};
          end else begin
            rem <= {rem[COUNT_W-2:0], quo[VALUE_W-1]};
            quo <= {quo[VALUE_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(VALUE_W - 1)) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          if (ovf) begin
            result <= sat32(sign, {1'b1, {VALUE_W{1'b0}}});
          end else begin
            result <= sat32(sign && !zero_q, {1'b0, quo});
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/odo_checker.sv =====
// ============================================================================
// Odometry port checker
// Watches the top-level ports for handshake and result consistency.
// ============================================================================
`timescale 1ns / 1ps

module odo_checker import odo_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input odo_in_t              in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input odo_out_t             out_data
);

  // A stalled sample beat is held unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("sample beat changed while stalled");

  // A stalled result beat is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Speeds are zero whenever they are flagged as not valid.
  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.speed_valid |->
      out_data.linear_speed == '0 && out_data.angular_speed == '0)
    else $error("speed reported without speed_valid");

  // After taking a sample the unit is busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken while the first is in progress");

  // No result is shown straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind differential_drive_odometry_unit odo_checker u_odo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/tb.sv =====
// ============================================================================
// Odometry unit testbench
// Drives wheel-count samples into the odometry unit under random sender gaps
// and receiver stalls. A model of the fixed-point arithmetic runs alongside
// and predicts each result beat; the monitor checks every beat field by field.
// The gains are changed between runs of samples, the extremes among them.
// ============================================================================
`timescale 1ns / 1ps

module tb;
  import odo_pkg::*;

  // Indexes outside the register map: writes to these must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam longint unsigned MS_PER_SECOND = 1000;
  localparam int RANDOM_BLOCKS   = 6;
  localparam int BLOCK_SAMPLES   = 275;
  localparam int DRAIN_CYCLES    = 80;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  odo_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  odo_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;

  // Samples waiting to be driven and results predicted but not yet seen.
  odo_in_t  pending_samples[$];
  odo_out_t predicted_results[$];

  // Shadow copy of the gains and of the previous sample held by the block.
  logic [GAIN_W-1:0]  lin_gain_shadow = LINEAR_GAIN_RESET;
  logic [GAIN_W-1:0]  ang_gain_shadow = ANGULAR_GAIN_RESET;
  logic [COUNT_W-1:0] prev_left  = '0;
  logic [COUNT_W-1:0] prev_right = '0;
  logic [COUNT_W-1:0] prev_time  = '0;
  logic               have_prev  = 1'b0;

  // Stimulus generator's own view of the last sample sent.
  logic [COUNT_W-1:0] gen_left  = '0;
  logic [COUNT_W-1:0] gen_right = '0;
  logic [COUNT_W-1:0] gen_time  = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int gain_settings = 0;

  differential_drive_odometry_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Clamp a sign and magnitude pair to a 32-bit two's complement word.
  function automatic logic [VALUE_W-1:0] saturate_word(input bit neg,
                                                       input longint unsigned mag);
    longint unsigned lim;
    if (neg) begin
      lim = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
      return VALUE_W'(64'd0 - lim);
    end
    lim = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
    return lim[VALUE_W-1:0];
  endfunction

  // Signed tick count times a Q0.32 gain, rounded half away from zero to Q16.16.
  function automatic logic [VALUE_W-1:0] q16_scale(input logic signed [17:0] ticks,
                                                   input logic [GAIN_W-1:0] gain);
    longint          wide;
    longint unsigned mag;
    longint unsigned rounded;
    wide = ticks;
    mag = (wide < 0) ? longint'(-wide) : longint'(wide);
    rounded = (mag * gain + 64'h8000) >> 16;
    return saturate_word(wide < 0 && rounded != 0, rounded);
  endfunction

  // Displacement per elapsed milliseconds scaled to per second, truncated.
  function automatic logic [VALUE_W-1:0] per_second(input logic [VALUE_W-1:0] disp,
                                                    input logic [COUNT_W-1:0] dt);
    bit              neg;
    longint unsigned mag;
    neg = disp[VALUE_W-1];
    mag = neg ? {32'd0, ~disp + 32'd1} : {32'd0, disp};
    mag = mag * MS_PER_SECOND / dt;
    return saturate_word(neg && mag != 0, mag);
  endfunction

  // Work out the result beat for one accepted sample and advance the shadow state.
  task automatic predict_motion(input odo_in_t s, output odo_out_t r);
    logic [COUNT_W-1:0] raw_l;
    logic [COUNT_W-1:0] raw_r;
    logic [COUNT_W-1:0] dt;
    logic signed [16:0] dl;
    logic signed [16:0] dr;
    logic signed [17:0] tick_sum;
    logic signed [17:0] turn_ticks;
    dl = '0;
    dr = '0;
    if (have_prev) begin
      raw_l = s.left_count - prev_left;
      raw_r = s.right_count - prev_right;
      dl = {raw_l[COUNT_W-1], raw_l};
      dr = {raw_r[COUNT_W-1], raw_r};
    end
    tick_sum   = {dl[16], dl} + {dr[16], dr};
    turn_ticks = {dr[16], dr} - {dl[16], dl};
    r = '0;
    r.translation = q16_scale(tick_sum, lin_gain_shadow);
    r.rotation    = q16_scale(turn_ticks, ang_gain_shadow);
    dt = s.time_ms - prev_time;
    if (have_prev && dt != 0) begin
      r.speed_valid   = 1'b1;
      r.linear_speed  = per_second(r.translation, dt);
      r.angular_speed = per_second(r.rotation, dt);
    end
    prev_left  = s.left_count;
    prev_right = s.right_count;
    prev_time  = s.time_ms;
    have_prev  = 1'b1;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("tb: mismatch on %s: got %h, predicted %h (beat %0d)",
             what, got, want, results_checked);
    mismatch_count++;
  endtask

  // One register write; the shadow follows only the indexes that exist.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_LINEAR_GAIN:  lin_gain_shadow = val;
      REG_ANGULAR_GAIN: ang_gain_shadow = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] lin, input logic [GAIN_W-1:0] ang);
    write_reg(REG_LINEAR_GAIN, lin);
    write_reg(REG_ANGULAR_GAIN, ang);
    gain_settings++;
  endtask

  task automatic push_sample(input logic [COUNT_W-1:0] l, input logic [COUNT_W-1:0] r,
                             input logic [COUNT_W-1:0] t);
    odo_in_t s;
    s.left_count  = l;
    s.right_count = r;
    s.time_ms     = t;
    pending_samples.push_back(s);
    gen_left  = l;
    gen_right = r;
    gen_time  = t;
  endtask

  // Mostly plausible motion with random step sizes; the rest is raw noise.
  task automatic queue_random_sample();
    int span;
    int dl;
    int dr;
    int dt;
    if ($urandom_range(0, 99) < 75) begin
      case ($urandom_range(0, 3))
        0: span = 3;
        1: span = 40;
        2: span = 1500;
        default: span = 32768;
      endcase
      dl = int'($urandom_range(0, 2 * span)) - span;
      dr = int'($urandom_range(0, 2 * span)) - span;
      case ($urandom_range(0, 9))
        0: dt = 0;
        1: dt = 1;
        2: dt = $urandom_range(0, 65535);
        3: dt = 65535;
        default: dt = $urandom_range(17, 23);
      endcase
      push_sample(COUNT_W'(gen_left + dl), COUNT_W'(gen_right + dr), COUNT_W'(gen_time + dt));
    end else begin
      push_sample(COUNT_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom));
    end
  endtask

  // Idle means nothing left to drive, nothing on the input and nothing outstanding.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  // Driver: presents queued samples, holding each beat steady while stalled.
  always @(posedge clk) begin
    odo_out_t want;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_motion(in_data, want);
        predicted_results.push_back(want);
        samples_sent++;
      end
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    odo_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          flag_mismatch("result with nothing predicted", out_data.translation, '0);
        end else begin
          want = predicted_results.pop_front();
          if (out_data.translation !== want.translation)
            flag_mismatch("translation", out_data.translation, want.translation);
          if (out_data.rotation !== want.rotation)
            flag_mismatch("rotation", out_data.rotation, want.rotation);
          if (out_data.linear_speed !== want.linear_speed)
            flag_mismatch("linear_speed", out_data.linear_speed, want.linear_speed);
          if (out_data.angular_speed !== want.angular_speed)
            flag_mismatch("angular_speed", out_data.angular_speed, want.angular_speed);
          if (out_data.speed_valid !== want.speed_valid)
            flag_mismatch("speed_valid", 32'(out_data.speed_valid), 32'(want.speed_valid));
          results_checked++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Main sequence: reset, directed samples, then random blocks per gain setting.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Writes to unmapped indexes must leave the default gains in place.
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h1234_5678);
    send_idle_pct = 28;
    recv_idle_pct = 50;
    @(negedge clk);

    // First sample, then zero elapsed time with motion.
    push_sample(16'h0064, 16'h00C8, 16'h0032);
    push_sample(16'h0096, 16'h0104, 16'h0032);
    // Half-range deltas read as negative, next to the largest positive step.
    push_sample(16'h8096, 16'h8103, 16'h0046);
    push_sample(16'h0096, 16'h0104, 16'h0047);
    // All-ones and all-zeros fields, timestamp wrapping by one.
    push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(16'h0000, 16'h0000, 16'h0000);
    push_sample(16'h0000, 16'h0000, 16'hFFFF);
    // Count wrap in both directions and a timestamp wrap.
    push_sample(16'h0005, 16'hFFFB, 16'h0009);
    push_sample(16'h0005, 16'hFFFB, 16'h001D);
    push_sample(16'h0019, 16'h0023, 16'h0031);
    push_sample(16'h0005, 16'h0005, 16'h0045);
    // Extreme sums and differences over one millisecond.
    push_sample(16'h8004, 16'h8004, 16'h0046);
    push_sample(16'h0004, 16'h0004, 16'h0047);
    push_sample(16'h8004, 16'h8003, 16'h0048);
    push_sample(16'h0003, 16'h0003, 16'h0049);
    push_sample(16'hAAAA, 16'h5555, 16'h5555);
    push_sample(16'h5555, 16'hAAAA, 16'hAAAA);
    gain_settings++;
    wait_idle();

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk)
        0: set_gains(LINEAR_GAIN_RESET, ANGULAR_GAIN_RESET);
        1: set_gains(32'h0000_0000, 32'hFFFF_FFFF);
        2: set_gains(32'hFFFF_FFFF, 32'h0000_0000);
        3: set_gains($urandom, $urandom);
        4: set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: set_gains($urandom_range(0, 32'h00FF_FFFF), $urandom);
      endcase
      write_reg((blk % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      send_idle_pct = (blk < 2) ? 28 : (blk < 4) ? 50 : 0;
      recv_idle_pct = (blk < 2) ? 50 : (blk < 4) ? 28 : 0;
      @(negedge clk);
      repeat (BLOCK_SAMPLES) queue_random_sample();
      wait_idle();
    end

    // Let any stray late beat show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d samples driven over %0d gain settings, %0d result beats checked",
             samples_sent, gain_settings, results_checked);
    $display("tb: %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(20_000_000);
    $display("tb: timed out with %0d results outstanding", predicted_results.size());
    $display("tb: FAIL");
    $finish;
  end

endmodule
